// ----- rtl/core/cfr_pkg.sv -----
// shared constants, types and the crc byte update for the framed command receiver
`timescale 1ns / 1ps

package cfr_pkg;

    // frame buffer span: the byte counter wraps after this many bytes
    localparam int BUFFER_BYTES = 256;
    localparam int CNT_W        = $clog2(BUFFER_BYTES);
    localparam int CNT1_W       = CNT_W + 1;

    localparam logic [7:0]  SYNC_BYTE    = 8'h6E;
    localparam logic [7:0]  TYPE_COMMAND = 8'h40;
    localparam logic [7:0]  TYPE_BULK    = 8'h30;
    localparam logic [7:0]  TYPE_SHORT   = 8'h20;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'h0000;
    localparam logic [15:0] MIN_FRAME    = 16'd6;

    // command codes and the events they raise
    localparam logic [7:0] CMD_REPORT = 8'h01;
    localparam logic [7:0] CMD_START  = 8'h02;
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_REPORT  = 2'd1;
    localparam logic [1:0] EV_START   = 2'd2;

    typedef struct packed {
        logic [7:0] command_code;
        logic [1:0] event_kind;
        logic [7:0] frame_length;
        logic       crc_match;
    } result_t;

    typedef struct packed {
        logic    hit;
        result_t data;
    } parse_result_t;

    // crc-16/xmodem, one byte msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/crc16_framed_command_receiver_top.sv -----
// top level of the framed command receiver: input beat register, parser, result register
`timescale 1ns / 1ps

// framed command receiver. takes one received byte per input beat and hunts for
// frames: sync 0x6e, type, 16-bit big-endian total length, property, command,
// payload, then a big-endian crc-16/xmodem over all bytes but the last two.
// type 0x20 frames are dropped after their third byte, types other than 0x40,
// 0x30 and 0x20 after their fifth; type 0x30 bytes (and command frames whose
// length reaches the 256-byte counter span) are swallowed until the counter
// wraps. command frames declaring fewer than 6 bytes are dropped at byte four.
// when a type 0x40 frame reaches its declared length one output beat carries
// the command byte, the event (1 report code request, 2 update start request,
// 0 other), the low length byte and the crc match flag; a crc mismatch is only
// reported, the frame is not dropped. throughput is one byte per clock: the
// input register feeds a single processing stage (byte-wide crc update, counter
// step and completion decode) whose result lands in the output register, so a
// result is offered on the output from that register once its last byte is processed.
// bytes keep flowing while the output register is empty or being read; only a
// result still held against a low m_axis_tready stops the processing stage.
// no clearing pass after reset.
module crc16_framed_command_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] command_code, [15:8] frame_length
    output logic [2:0]  m_axis_tuser    // [1:0] event_kind, [2] crc_match
);
    import cfr_pkg::*;

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_data_reg;
    logic          out_free;
    logic          fire;
    parse_result_t res;

    // processing stage moves when a byte is held and the result slot can take it
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    cfr_frame_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;

        out_valid_next = out_valid_reg;
        if (fire && res.hit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (fire && res.hit)
            out_data_reg <= res.data;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.frame_length, out_data_reg.command_code};
    assign m_axis_tuser  = {out_data_reg.crc_match, out_data_reg.event_kind};

    // an empty input register never refuses a beat
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while empty");

    // a held result is never overwritten by a new completion
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !fire)
        else $error("processing stage advanced over a held result");

    // every result carries a legal event code
    a_event_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == EV_NONE || m_axis_tuser[1:0] == EV_REPORT ||
                           m_axis_tuser[1:0] == EV_START))
        else $error("illegal event code on output");

endmodule

// ----- rtl/core/cfr_frame_parser.sv -----
// frame state, crc history and completion decode, one byte per enabled cycle
`timescale 1ns / 1ps

module cfr_frame_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            rx_byte,
    output cfr_pkg::parse_result_t result
);
    import cfr_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [15:0]      length_reg, length_next;
    logic [7:0]       command_reg, command_next;
    logic [15:0]      crc_run_reg, crc_run_next;
    logic [15:0]      crc_one_reg, crc_one_next;
    logic [15:0]      crc_two_next;
    logic [7:0]       prev_reg;

    logic [15:0]      crc_base;
    logic [CNT1_W-1:0] cnt;
    logic [15:0]      cnt_ext;
    logic             hit;
    logic [1:0]       ev;

    // crc history restarts at the first byte of a frame
    always_comb
    begin
        crc_base     = (count_reg == '0) ? CRC_INIT : crc_run_reg;
        crc_run_next = crc_update(crc_base, rx_byte);
        crc_one_next = crc_base;
        crc_two_next = (count_reg == '0) ? CRC_INIT : crc_one_reg;
    end

    always_comb
    begin
        frame_type_next = (count_reg == CNT_W'(1)) ? rx_byte : frame_type_reg;
        command_next    = (count_reg == CNT_W'(5)) ? rx_byte : command_reg;
        if (count_reg == CNT_W'(2))
            length_next = {rx_byte, 8'h00};
        else if (count_reg == CNT_W'(3))
            length_next = {length_reg[15:8], rx_byte};
        else
            length_next = length_reg;
    end

    always_comb
    begin
        hit = 1'b0;
        cnt = {1'b0, count_reg} + CNT1_W'(1);
        if (cnt >= CNT1_W'(BUFFER_BYTES))
            cnt = '0;
        if (cnt == CNT1_W'(1) && rx_byte != SYNC_BYTE)
            cnt = '0;
        if (cnt == CNT1_W'(5) && frame_type_next != TYPE_COMMAND &&
            frame_type_next != TYPE_BULK && frame_type_next != TYPE_SHORT)
            cnt = '0;
        if (cnt >= CNT1_W'(3) && frame_type_next == TYPE_SHORT)
            cnt = '0;
        cnt_ext = 16'(cnt);
        if (cnt >= CNT1_W'(4) && frame_type_next == TYPE_COMMAND)
        begin
            if (length_next < MIN_FRAME)
                cnt = '0;
            else if (cnt_ext >= length_next)
            begin
                hit = 1'b1;
                cnt = '0;
            end
        end
        count_next = cnt[CNT_W-1:0];
    end

    always_comb
    begin
        unique case (command_next)
            CMD_REPORT: ev = EV_REPORT;
            CMD_START:  ev = EV_START;
            default:    ev = EV_NONE;
        endcase
    end

    assign result.hit               = hit;
    assign result.data.command_code = command_next;
    assign result.data.event_kind   = ev;
    assign result.data.frame_length = length_next[7:0];
    assign result.data.crc_match    = ({prev_reg, rx_byte} == crc_two_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            frame_type_reg <= '0;
            length_reg     <= '0;
            command_reg    <= '0;
            crc_run_reg    <= CRC_INIT;
            crc_one_reg    <= CRC_INIT;
            prev_reg       <= '0;
        end
        else if (step_en)
        begin
            count_reg      <= count_next;
            frame_type_reg <= frame_type_next;
            length_reg     <= length_next;
            command_reg    <= command_next;
            crc_run_reg    <= crc_run_next;
            crc_one_reg    <= crc_one_next;
            prev_reg       <= rx_byte;
        end
    end

    // a completed frame always restarts the hunt
    a_hit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && hit) |=> (count_reg == '0))
        else $error("counter not cleared after frame completion");

    // short frames never get past the third byte
    a_short_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(3)) |-> (frame_type_reg != TYPE_SHORT))
        else $error("short frame counted past byte three");

    // a completion only comes from a command frame of legal length
    a_hit_legal: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (frame_type_next == TYPE_COMMAND && length_next >= MIN_FRAME))
        else $error("completion from an illegal frame");

endmodule

// ----- bench/tb_crc16_framed_command_receiver_top.sv -----
// testbench for the framed command receiver: directed frame table, random frames, self-check
`timescale 1ns / 1ps

module tb_crc16_framed_command_receiver_top;

    import cfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BEATS = 480;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int          ROWS         = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] command_code, [15:8] frame_length
    logic [2:0]  m_axis_tuser;             // [1:0] event_kind, [2] crc_match

    crc16_framed_command_receiver_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // frame tracker: mirrors the parser byte by byte
    // ------------------------------------------------------------------
    int unsigned frame_pos  = 0;        // bytes taken of the current frame, 0 = hunting
    logic [7:0]  frame_kind = 8'h00;
    logic [15:0] frame_len  = 16'h0000;
    logic [7:0]  frame_cmd  = 8'h00;
    logic [15:0] crc_all    = 16'h0000; // over every byte so far
    logic [15:0] crc_less1  = 16'h0000; // all but the newest byte
    logic [15:0] crc_less2  = 16'h0000; // all but the newest two
    logic [7:0]  last_rx    = 8'h00;

    result_t     awaited_reports[$];
    bit          row_is_typed = 1'b0;   // table row carries its own expected report
    int unsigned error_count  = 0;
    int unsigned frame_beats  = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          hold_req = 1'b0;

    // xmodem crc, bit serial, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // advance the tracker by one accepted byte and queue the report it completes, unless the row carries its own
    task automatic track_rx_byte(input logic [7:0] b);
        logic [7:0]  held;
        int unsigned nxt;
        result_t     rep;
        held = last_rx;
        if (frame_pos == 0)
        begin
            crc_all   = CRC_INIT;
            crc_less1 = CRC_INIT;
            crc_less2 = CRC_INIT;
        end
        crc_less2 = crc_less1;
        crc_less1 = crc_all;
        crc_all   = crc_step(crc_all, b);
        case (frame_pos)
            1: frame_kind = b;
            2: frame_len = {b, 8'h00};
            3: frame_len[7:0] = b;
            5: frame_cmd = b;
            default: ;
        endcase
        last_rx = b;

        nxt = frame_pos + 1;
        if (nxt >= BUFFER_BYTES)
            nxt = 0;
        // lost sync: only the sync byte opens a frame
        if (nxt == 1 && b != SYNC_BYTE)
            nxt = 0;
        // unknown type gives up after the fifth byte
        if (nxt == 5 && frame_kind != TYPE_COMMAND && frame_kind != TYPE_BULK &&
            frame_kind != TYPE_SHORT)
            nxt = 0;
        if (nxt >= 3 && frame_kind == TYPE_SHORT)
            nxt = 0;
        if (nxt >= 4 && frame_kind == TYPE_COMMAND)
        begin
            if (frame_len < MIN_FRAME)
                nxt = 0;
            else if (nxt >= frame_len)
            begin
                rep.command_code = frame_cmd;
                rep.event_kind   = (frame_cmd == CMD_REPORT) ? EV_REPORT :
                                   (frame_cmd == CMD_START)  ? EV_START  : EV_NONE;
                rep.frame_length = frame_len[7:0];
                rep.crc_match    = ({held, b} == crc_less2);
                if (!row_is_typed)
                    awaited_reports.push_back(rep);
                nxt = 0;
            end
        end
        frame_pos = nxt;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // sender: drives at the falling edge, sees acceptance at the rising edge
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_rx_byte(b);
        @(negedge clk);
    endtask

    // builds one frame of the given type; the byte count follows how the
    // parser treats that type, so each call ends back in the hunting state
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input logic [7:0] cmd, input logic bad_crc,
                              input logic rnd_fill, input logic [7:0] fill);
        logic [7:0]  frame_bytes [0:255];
        int          n;
        logic [15:0] crc;
        if (ftype == TYPE_SHORT)
            n = 3;
        else if (ftype == TYPE_BULK)
            n = BUFFER_BYTES;
        else if (ftype != TYPE_COMMAND)
            n = 5;
        else if (flen < MIN_FRAME)
            n = 4;
        else if (flen >= BUFFER_BYTES)
            n = BUFFER_BYTES;
        else
            n = int'(flen);
        for (int i = 0; i < n; i++)
            frame_bytes[i] = rnd_fill ? 8'($urandom) : fill;
        frame_bytes[0] = SYNC_BYTE;
        frame_bytes[1] = ftype;
        frame_bytes[2] = flen[15:8];
        if (n > 3)
            frame_bytes[3] = flen[7:0];
        if (n > 5)
            frame_bytes[5] = cmd;
        // complete command frame: trailer crc, possibly with one bit flipped
        if (ftype == TYPE_COMMAND && flen >= MIN_FRAME && flen < BUFFER_BYTES)
        begin
            crc = CRC_INIT;
            for (int i = 0; i < n - 2; i++)
                crc = crc_step(crc, frame_bytes[i]);
            if (bad_crc)
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frame_bytes[n-2] = crc[15:8];
            frame_bytes[n-1] = crc[7:0];
        end
        for (int i = 0; i < n; i++)
            push_byte(frame_bytes[i]);
        frame_beats += n;
    endtask

    // ------------------------------------------------------------------
    // directed frames
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       noise;     // a single loose byte instead of a frame
        logic [7:0] ftype;
        logic [15:0] flen;
        logic [7:0] cmd;
        logic       bad_crc;
        logic [7:0] fill;      // payload byte, or the loose byte
        logic       typed;     // expected report is written out below
        result_t    want;
    } stim_row_t;

    stim_row_t stim_rows [ROWS] = '{
        // no sync: loose bytes are discarded
        '{1'b1, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        '{1'b1, 8'h00, 16'd0, 8'h00, 1'b0, 8'hFF, 1'b0, '0},
        // one frame per command class, good and bad crc
        '{1'b0, TYPE_COMMAND, 16'd8, CMD_REPORT, 1'b0, 8'h00, 1'b1,
          '{CMD_REPORT, EV_REPORT, 8'd8, 1'b1}},
        '{1'b0, TYPE_COMMAND, 16'd9, CMD_START, 1'b0, 8'hFF, 1'b1,
          '{CMD_START, EV_START, 8'd9, 1'b1}},
        '{1'b0, TYPE_COMMAND, 16'd10, 8'hFF, 1'b1, 8'h55, 1'b1,
          '{8'hFF, EV_NONE, 8'd10, 1'b0}},
        '{1'b0, TYPE_COMMAND, 16'd8, 8'h00, 1'b0, 8'h00, 1'b1,
          '{8'h00, EV_NONE, 8'd8, 1'b1}},
        // minimum lengths: the trailer overlaps the header bytes
        '{1'b0, TYPE_COMMAND, 16'd6, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, TYPE_COMMAND, 16'd7, 8'h00, 1'b0, 8'hFF, 1'b0, '0},
        // longest frame that still completes
        '{1'b0, TYPE_COMMAND, 16'd255, CMD_REPORT, 1'b0, 8'hAA, 1'b1,
          '{CMD_REPORT, EV_REPORT, 8'd255, 1'b1}},
        // declared length below the minimum
        '{1'b0, TYPE_COMMAND, 16'd5, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, TYPE_COMMAND, 16'd0, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        // short type, dropped on a sync-valued third byte that must not resync
        '{1'b0, TYPE_SHORT, 16'h6E00, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, TYPE_COMMAND, 16'd8, CMD_START, 1'b0, 8'h11, 1'b1,
          '{CMD_START, EV_START, 8'd8, 1'b1}},
        // unknown types, in the first the dropping byte again sync-valued
        '{1'b0, 8'h00, 16'h0008, 8'h00, 1'b0, SYNC_BYTE, 1'b0, '0},
        '{1'b0, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 8'hFF, 1'b0, '0},
        // bulk type swallows a full counter span full of sync bytes
        '{1'b0, TYPE_BULK, 16'h0000, 8'h00, 1'b0, SYNC_BYTE, 1'b0, '0},
        // after the wrap the very next byte is a sync
        '{1'b0, TYPE_COMMAND, 16'd8, CMD_REPORT, 1'b0, 8'h00, 1'b1,
          '{CMD_REPORT, EV_REPORT, 8'd8, 1'b1}},
        // lengths past the counter span never complete
        '{1'b0, TYPE_COMMAND, 16'h0100, 8'h00, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, TYPE_COMMAND, 16'hFFFF, 8'hFF, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, TYPE_COMMAND, 16'd12, CMD_START, 1'b1, 8'h3C, 1'b1,
          '{CMD_START, EV_START, 8'd12, 1'b0}}
    };

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int unsigned mark;
        int unsigned waited;
        logic [7:0]  t;
        logic [7:0]  c;
        logic [15:0] len;
        bit          paused;

        paused = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
        begin
            row_is_typed = stim_rows[i].typed;
            if (stim_rows[i].noise)
                push_byte(stim_rows[i].fill);
            else
                send_frame(stim_rows[i].ftype, stim_rows[i].flen, stim_rows[i].cmd,
                           stim_rows[i].bad_crc, 1'b0, stim_rows[i].fill);
            if (stim_rows[i].typed)
                awaited_reports.push_back(stim_rows[i].want);
            row_is_typed = 1'b0;
        end

        // let the receiver stall for a long stretch while frames keep coming
        hold_req = 1'b1;
        mark = frame_beats;
        while (frame_beats < mark + RANDOM_BEATS)
        begin
            // halfway: sender stops until every report is out
            if (!paused && frame_beats >= mark + RANDOM_BEATS / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid = 1'b0;
                while (awaited_reports.size() != 0)
                    @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // well-formed command frame, random content
                len = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(6, 40))
                                                  : 16'($urandom_range(41, 255));
                case ($urandom_range(0, 9))
                    0, 1, 2: c = CMD_REPORT;
                    3, 4, 5: c = CMD_START;
                    default: c = 8'($urandom);
                endcase
                send_frame(TYPE_COMMAND, len, c, $urandom_range(0, 4) == 0, 1'b1, 8'h00);
            end
            else if (r < 78)
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom));
            end
            else if (r < 84)
                send_frame(TYPE_COMMAND, 16'($urandom_range(0, 5)), 8'($urandom), 1'b0,
                           1'b1, 8'h00);
            else if (r < 89)
                send_frame(TYPE_SHORT, 16'($urandom), 8'($urandom), 1'b0, 1'b1, 8'h00);
            else if (r < 94)
            begin
                do
                    t = 8'($urandom);
                while (t == TYPE_COMMAND || t == TYPE_BULK || t == TYPE_SHORT);
                send_frame(t, 16'($urandom), 8'($urandom), 1'b0, 1'b1, 8'h00);
            end
            else if (r < 95)
                send_frame(TYPE_BULK, 16'($urandom), 8'($urandom), 1'b0, 1'b1, 8'h00);
            else if (r < 96)
                send_frame(TYPE_COMMAND, 16'($urandom_range(256, 65535)), 8'($urandom),
                           1'b0, 1'b1, 8'h00);
            else
            begin
                // broken frame: header then junk, the tracker follows wherever it leads
                push_byte(SYNC_BYTE);
                push_byte(TYPE_COMMAND);
                repeat ($urandom_range(1, 10))
                    push_byte(8'($urandom));
            end
        end
        s_axis_tvalid = 1'b0;

        // drain, bounded so a lost report is reported rather than hung on
        waited = 0;
        while (awaited_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_reports.size() != 0)
        begin
            $error("%0d expected reports never arrived", awaited_reports.size());
            error_count++;
        end
        // two-stage pipe: keep clocking before the finish to catch any stray beat
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random ready, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                rx_quiet = !rx_quiet;
            if (stall_left != 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                stall_left = rx_quiet ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: every output beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.command_code = m_axis_tdata[7:0];
            got.frame_length = m_axis_tdata[15:8];
            got.event_kind   = m_axis_tuser[1:0];
            got.crc_match    = m_axis_tuser[2];
            if (awaited_reports.size() == 0)
            begin
                $error("unexpected report: command_code %0h frame_length %0d",
                       got.command_code, got.frame_length);
                error_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (got.command_code !== want.command_code)
                begin
                    $error("command_code: expected %0h, got %0h",
                           want.command_code, got.command_code);
                    error_count++;
                end
                if (got.event_kind !== want.event_kind)
                begin
                    $error("event_kind: expected %0d, got %0d",
                           want.event_kind, got.event_kind);
                    error_count++;
                end
                if (got.frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, got.frame_length);
                    error_count++;
                end
                if (got.crc_match !== want.crc_match)
                begin
                    $error("crc_match: expected %0b, got %0b",
                           want.crc_match, got.crc_match);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cfr_pkg.sv
rtl/core/cfr_frame_parser.sv
rtl/core/crc16_framed_command_receiver_top.sv
bench/tb_crc16_framed_command_receiver_top.sv
